// ===== rtl/lifo_stack_multi_pop_assert.svh =====
// ----------------------------------------------------------------------------
// lifo_stack_multi_pop_assert.svh
// Assertion macros for the LIFO stack. Outside simulation they expand to nothing.
// ----------------------------------------------------------------------------
`ifndef LIFO_STACK_MULTI_POP_ASSERT_SVH
`define LIFO_STACK_MULTI_POP_ASSERT_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante
`define LSMP_ASSERT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lsmp assertion failed");

// Check that cons holds in the cycle after ante
`define LSMP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lsmp assertion failed");

`else

`define LSMP_ASSERT(lbl, clk, rst, ante, cons)
`define LSMP_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/lsmp_pkg.sv =====
// ----------------------------------------------------------------------------
// lsmp_pkg
// Shared sizes, codes and structs for the LIFO stack with multi-word pop.
// ----------------------------------------------------------------------------
package lsmp_pkg;

   // Stack sizing
   localparam int DEPTH  = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam int WORD_W = 32;
   localparam int CNT_W  = 7;

   localparam logic signed [WORD_W-1:0] WORD_MINUS_ONE = '1;

   // Command codes
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_PUSH   = 2'd0,
      KIND_POPPED = 2'd1,
      KIND_EMPTY  = 2'd2,
      KIND_ZERO   = 2'd3
   } kind_type;

   // One result transaction
   typedef struct packed {
      kind_type                  kind;
      logic signed [WORD_W-1:0]  popped_value;
      logic                      last;
      logic [FILL_W-1:0]         fill;
      logic                      is_empty;
      logic signed [WORD_W-1:0]  top_value;
      logic                      overflow;
   } result_type;

   // Memory access request from the controller
   typedef struct packed {
      logic                      wr_en;
      logic [ADDR_W-1:0]         wr_addr;
      logic signed [WORD_W-1:0]  wr_data;
      logic                      rd_en;
      logic [ADDR_W-1:0]         rd_addr;
   } mem_req_type;

endpackage

// ===== rtl/lsmp_store.sv =====
// ----------------------------------------------------------------------------
// lsmp_store
// Stack word memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lsmp_store (
   input  logic                                 clock,
   input  lsmp_pkg::mem_req_type                mem_req,
   output logic signed [lsmp_pkg::WORD_W-1:0]   rd_data
);

   logic signed [lsmp_pkg::WORD_W-1:0] mem [lsmp_pkg::DEPTH];
   logic signed [lsmp_pkg::WORD_W-1:0] rd_data_ff;

   // Write the pushed word
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   // Registered read; hold data while not enabled
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/lsmp_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsmp_ctrl
// Stack controller: fill count, cached top word, pop sequencer and memory
// access. The word below the top is prefetched from memory ahead of each pop.
// ----------------------------------------------------------------------------
`include "lifo_stack_multi_pop_assert.svh"

module lsmp_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_cmd,
   input  logic signed [lsmp_pkg::WORD_W-1:0]   req_push_value,
   input  logic [lsmp_pkg::CNT_W-1:0]           req_pop_count,
   input  logic                                 out_free,
   output logic                                 res_load,
   output lsmp_pkg::result_type                 res,
   output lsmp_pkg::mem_req_type                mem_req,
   input  logic signed [lsmp_pkg::WORD_W-1:0]   rd_data
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_POP  = 2'b10
   } state_type;

   state_type                            state_ff, state_in;
   logic [lsmp_pkg::FILL_W-1:0]          fill_ff, fill_in;
   logic [lsmp_pkg::FILL_W-1:0]          rem_ff, rem_in;
   logic signed [lsmp_pkg::WORD_W-1:0]   top_ff, top_in;

   logic                                 accept;
   logic                                 step;
   logic                                 full;
   logic [lsmp_pkg::FILL_W-1:0]          fill_m1;
   logic [lsmp_pkg::FILL_W-1:0]          fill_m2;
   logic [lsmp_pkg::FILL_W-1:0]          fill_m3;
   logic [lsmp_pkg::CNT_W-1:0]           fill_cnt;
   logic [lsmp_pkg::CNT_W-1:0]           run_len;

   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign step      = (state_ff == ST_POP) && out_free;

   assign full     = (fill_ff == lsmp_pkg::FILL_W'(lsmp_pkg::DEPTH));
   assign fill_m1  = fill_ff - lsmp_pkg::FILL_W'(1);
   assign fill_m2  = fill_ff - lsmp_pkg::FILL_W'(2);
   assign fill_m3  = fill_ff - lsmp_pkg::FILL_W'(3);
   assign fill_cnt = lsmp_pkg::CNT_W'(fill_ff);
   assign run_len  = (req_pop_count < fill_cnt) ? req_pop_count : fill_cnt;

   // Decode the command, sequence pops and drive the memory
   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      rem_in   = rem_ff;
      top_in   = top_ff;
      res_load = 1'b0;

      res.kind         = lsmp_pkg::KIND_PUSH;
      res.popped_value = '0;
      res.last         = 1'b1;
      res.fill         = fill_ff;
      res.is_empty     = (fill_ff == '0);
      res.top_value    = (fill_ff == '0) ? lsmp_pkg::WORD_MINUS_ONE : top_ff;
      res.overflow     = 1'b0;

      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = lsmp_pkg::ADDR_W'(fill_ff);
      mem_req.wr_data = req_push_value;
      mem_req.rd_en   = 1'b0;
      mem_req.rd_addr = lsmp_pkg::ADDR_W'(fill_m3);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == lsmp_pkg::CMD_PUSH) begin
                  res_load = 1'b1;
                  if (full) begin
                     // Drop the word and flag it
                     res.overflow = 1'b1;
                  end else begin
                     mem_req.wr_en = 1'b1;
                     fill_in       = fill_ff + lsmp_pkg::FILL_W'(1);
                     top_in        = req_push_value;
                     res.fill      = fill_in;
                     res.is_empty  = 1'b0;
                     res.top_value = req_push_value;
                  end
               end else if (fill_ff == '0) begin
                  res_load         = 1'b1;
                  res.kind         = lsmp_pkg::KIND_EMPTY;
                  res.popped_value = lsmp_pkg::WORD_MINUS_ONE;
               end else if (req_pop_count == '0) begin
                  res_load = 1'b1;
                  res.kind = lsmp_pkg::KIND_ZERO;
               end else begin
                  // Start a run; prefetch the word below the top
                  state_in        = ST_POP;
                  rem_in          = lsmp_pkg::FILL_W'(run_len);
                  mem_req.rd_en   = (fill_ff >= lsmp_pkg::FILL_W'(2));
                  mem_req.rd_addr = lsmp_pkg::ADDR_W'(fill_m2);
               end
            end
         end
         ST_POP: begin
            if (step) begin
               // Emit the cached top, promote the prefetched word
               res_load         = 1'b1;
               res.kind         = lsmp_pkg::KIND_POPPED;
               res.popped_value = top_ff;
               res.last         = (rem_ff == lsmp_pkg::FILL_W'(1));
               res.fill         = fill_m1;
               res.is_empty     = (fill_m1 == '0);
               res.top_value    = (fill_m1 == '0) ? lsmp_pkg::WORD_MINUS_ONE : rd_data;
               fill_in          = fill_m1;
               top_in           = rd_data;
               rem_in           = rem_ff - lsmp_pkg::FILL_W'(1);
               mem_req.rd_en    = (fill_ff >= lsmp_pkg::FILL_W'(3));
               if (rem_ff == lsmp_pkg::FILL_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         rem_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         rem_ff   <= rem_in;
      end
   end

   // Cached top word
   always_ff @(posedge clock) begin
      top_ff <= top_in;
   end

   `LSMP_ASSERT(a_fill_bound, clock, reset, 1'b1, fill_ff <= lsmp_pkg::FILL_W'(lsmp_pkg::DEPTH))
   `LSMP_ASSERT(a_run_nonzero, clock, reset, state_ff == ST_POP, rem_ff != '0 && fill_ff != '0)
   `LSMP_ASSERT_NEXT(a_pop_dec, clock, reset, step, fill_ff == $past(fill_ff) - 1'b1)
   `LSMP_ASSERT_NEXT(a_push_inc, clock, reset, accept && req_cmd == lsmp_pkg::CMD_PUSH && !full, fill_ff == $past(fill_ff) + 1'b1)

endmodule

// ===== rtl/lsmp_out.sv =====
// ----------------------------------------------------------------------------
// lsmp_out
// Result output register: holds one result transaction until it is taken.
// ----------------------------------------------------------------------------
module lsmp_out (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 res_load,
   input  lsmp_pkg::result_type                 res,
   output logic                                 out_free,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [1:0]                           rsp_kind,
   output logic signed [31:0]                   rsp_popped_value,
   output logic                                 rsp_last,
   output logic [6:0]                           rsp_fill,
   output logic                                 rsp_is_empty,
   output logic signed [31:0]                   rsp_top_value,
   output logic                                 rsp_overflow
);

   logic                  valid_ff;
   lsmp_pkg::result_type  res_ff;

   // Slot is free when empty or being drained this cycle
   assign out_free = !valid_ff || rsp_ready;

   // Hold valid until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (res_load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   // Capture payload
   always_ff @(posedge clock) begin
      if (res_load) begin
         res_ff <= res;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_kind         = 2'(res_ff.kind);
   assign rsp_popped_value = 32'(res_ff.popped_value);
   assign rsp_last         = res_ff.last;
   assign rsp_fill         = 7'(res_ff.fill);
   assign rsp_is_empty     = res_ff.is_empty;
   assign rsp_top_value    = 32'(res_ff.top_value);
   assign rsp_overflow     = res_ff.overflow;

endmodule

// ===== rtl/lifo_stack_multi_pop.sv =====
// ----------------------------------------------------------------------------
// lifo_stack_multi_pop
// Bounded LIFO stack of signed 32-bit words with push and multi-word pop.
//
//   channel | direction | handshake           | payload
//   req_    | in        | req_valid/req_ready | cmd, push_value, pop_count
//   rsp_    | out       | rsp_valid/rsp_ready | kind, popped_value, last, fill,
//           |           |                     | is_empty, top_value, overflow
//
// A push or a single-result pop gives one response; pushes are accepted every
// cycle while rsp_ready holds. A pop of n words prefetches the word below the
// top from the registered read port, then one word per cycle unless stalled.
// Reset clears fill, sequencer and output valid; memory needs no clearing.
// A stalled rsp_ channel holds the sequencer and the memory read data in place.
// ----------------------------------------------------------------------------
module lifo_stack_multi_pop (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_cmd,
   input  logic signed [31:0]   req_push_value,
   input  logic [6:0]           req_pop_count,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_kind,
   output logic signed [31:0]   rsp_popped_value,
   output logic                 rsp_last,
   output logic [6:0]           rsp_fill,
   output logic                 rsp_is_empty,
   output logic signed [31:0]   rsp_top_value,
   output logic                 rsp_overflow
);

   logic                                 out_free;
   logic                                 res_load;
   lsmp_pkg::result_type                 res;
   lsmp_pkg::mem_req_type                mem_req;
   logic signed [lsmp_pkg::WORD_W-1:0]   rd_data;

   // Sequence commands and track fill
   lsmp_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_push_value (req_push_value),
      .req_pop_count  (req_pop_count),
      .out_free       (out_free),
      .res_load       (res_load),
      .res            (res),
      .mem_req        (mem_req),
      .rd_data        (rd_data)
   );

   // Hold stack words
   lsmp_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // Register results
   lsmp_out u_out (
      .clock            (clock),
      .reset            (reset),
      .res_load         (res_load),
      .res              (res),
      .out_free         (out_free),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_popped_value (rsp_popped_value),
      .rsp_last         (rsp_last),
      .rsp_fill         (rsp_fill),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_top_value    (rsp_top_value),
      .rsp_overflow     (rsp_overflow)
   );

endmodule

// ===== tb/lifo_stack_multi_pop_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifo_stack_multi_pop_test
// Self-checking bench for the bounded LIFO stack with multi-word pop. A queue
// of push and pop transactions feeds a clocked driver. A shadow stack predicts
// every response, and a clocked monitor checks each response field by field.
// Both channels idle at random. The response side holds off for one long
// stretch so that the stack backs up and stalls its request channel.
// ----------------------------------------------------------------------------
module lifo_stack_multi_pop_test;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int RANDOM_OPS    = 210;
   localparam int LONG_HOLD     = 150;
   localparam int HOLD_AT_RSP   = 60;
   localparam int TAIL_CYCLES   = 12;
   localparam int MAX_REPORTS   = 10;

   typedef struct {
      logic                cmd;
      logic signed [31:0]  value;
      logic [6:0]          count;
      int unsigned         idle_cycles;
      bit                  drain_first;
   } stack_op_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_cmd = lsmp_pkg::CMD_PUSH;
   logic signed [31:0] req_push_value = '0;
   logic [6:0]         req_pop_count = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_kind;
   logic signed [31:0] rsp_popped_value;
   logic               rsp_last;
   logic [6:0]         rsp_fill;
   logic               rsp_is_empty;
   logic signed [31:0] rsp_top_value;
   logic               rsp_overflow;

   // Stimulus and shadow stack
   stack_op_type          pending_ops[$];
   stack_op_type          next_op;
   lsmp_pkg::result_type  awaited_results[$];
   logic signed [31:0]    shadow_words [lsmp_pkg::DEPTH];
   int                 shadow_fill = 0;
   int                 gen_fill = 0;
   int                 ops_total = 0;
   int                 ops_accepted = 0;
   int                 results_due = 0;
   int                 results_seen = 0;
   int                 mismatches = 0;
   int                 cycle_count = 0;
   int                 kind_tally [4] = '{0, 0, 0, 0};
   int                 dropped_pushes = 0;

   // Driver and receiver bookkeeping
   bit                 offering = 1'b0;
   bit                 staged = 1'b0;
   int unsigned        idle_left = 0;
   int unsigned        stall_left = 0;
   bit                 long_hold_done = 1'b0;

   lifo_stack_multi_pop dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_push_value   (req_push_value),
      .req_pop_count    (req_pop_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_popped_value (rsp_popped_value),
      .rsp_last         (rsp_last),
      .rsp_fill         (rsp_fill),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_top_value    (rsp_top_value),
      .rsp_overflow     (rsp_overflow)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Build one response from the shadow stack as it stands now
   function automatic lsmp_pkg::result_type stack_snapshot(lsmp_pkg::kind_type kind,
                                                           logic signed [31:0] word,
                                                           logic last, logic overflow);
      lsmp_pkg::result_type r;
      r.kind         = kind;
      r.popped_value = word;
      r.last         = last;
      r.fill         = shadow_fill[lsmp_pkg::FILL_W-1:0];
      r.is_empty     = (shadow_fill == 0);
      r.top_value    = (shadow_fill == 0) ? lsmp_pkg::WORD_MINUS_ONE
                                          : shadow_words[shadow_fill-1];
      r.overflow     = overflow;
      return r;
   endfunction

   // Apply one accepted transaction to the shadow stack and queue its responses
   task automatic apply_stack_op(input stack_op_type op);
      int n;
      if (op.cmd == lsmp_pkg::CMD_PUSH) begin
         if (shadow_fill >= lsmp_pkg::DEPTH) begin
            awaited_results.push_back(stack_snapshot(lsmp_pkg::KIND_PUSH, '0, 1'b1, 1'b1));
         end else begin
            shadow_words[shadow_fill] = op.value;
            shadow_fill++;
            awaited_results.push_back(stack_snapshot(lsmp_pkg::KIND_PUSH, '0, 1'b1, 1'b0));
         end
         results_due++;
      end else if (shadow_fill == 0) begin
         awaited_results.push_back(stack_snapshot(lsmp_pkg::KIND_EMPTY,
                                                  lsmp_pkg::WORD_MINUS_ONE, 1'b1, 1'b0));
         results_due++;
      end else if (op.count == 0) begin
         awaited_results.push_back(stack_snapshot(lsmp_pkg::KIND_ZERO, '0, 1'b1, 1'b0));
         results_due++;
      end else begin
         n = (op.count < shadow_fill) ? int'(op.count) : shadow_fill;
         for (int i = 0; i < n; i++) begin
            shadow_fill--;
            awaited_results.push_back(stack_snapshot(lsmp_pkg::KIND_POPPED,
                                                     shadow_words[shadow_fill],
                                                     i == n - 1, 1'b0));
         end
         results_due += n;
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("mismatch on response %0d, %s: expected %h, got %h",
                     results_seen, name, want, got);
      end
   endtask

   function automatic logic signed [31:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return lsmp_pkg::WORD_MINUS_ONE;
         3: return '0;
         default: return $urandom;
      endcase
   endfunction

   // Queue one transaction; track the fill so sequences can be shaped
   task automatic queue_op(input logic cmd, input logic signed [31:0] value,
                           input int count, input bit drain_first);
      stack_op_type op;
      op.cmd         = cmd;
      op.value       = value;
      op.count       = count[6:0];
      op.drain_first = drain_first;
      // Run every third stretch of 24 transactions back to back
      op.idle_cycles = ((pending_ops.size() / 24) % 3 == 1) ? 0 : $urandom_range(0, 4);
      pending_ops.push_back(op);
      if (cmd == lsmp_pkg::CMD_PUSH) begin
         if (gen_fill < lsmp_pkg::DEPTH)
            gen_fill++;
      end else begin
         gen_fill -= (count < gen_fill) ? count : gen_fill;
      end
   endtask

   task automatic queue_push(input bit drain_first);
      queue_op(lsmp_pkg::CMD_PUSH, pick_word(), $urandom_range(0, 64), drain_first);
   endtask

   task automatic queue_pop(input int count, input bit drain_first);
      queue_op(lsmp_pkg::CMD_POP, $urandom, count, drain_first);
   endtask

   // Stimulus, reset and end of run
   initial begin
      int  directed;
      int  full_runs;
      int  pick;
      bit  drain;

      // Directed: empty pops, word extremes, zero pop, exact and clipped pops
      queue_pop(0, 1'b0);
      queue_pop(64, 1'b0);
      queue_op(lsmp_pkg::CMD_PUSH, 32'sh8000_0000, 0, 1'b0);
      queue_op(lsmp_pkg::CMD_PUSH, 32'sh7FFF_FFFF, 64, 1'b0);
      queue_op(lsmp_pkg::CMD_PUSH, lsmp_pkg::WORD_MINUS_ONE, 127, 1'b0);
      queue_op(lsmp_pkg::CMD_PUSH, '0, 1, 1'b0);
      queue_pop(0, 1'b0);
      queue_pop(1, 1'b0);
      queue_op(lsmp_pkg::CMD_PUSH, 32'sh5A5A_A5A5, 0, 1'b0);
      queue_pop(2, 1'b0);
      queue_pop(64, 1'b0);
      queue_pop(1, 1'b0);
      repeat (3) queue_push(1'b0);
      queue_pop(3, 1'b0);
      queue_pop(0, 1'b0);
      directed = pending_ops.size();

      // Random: mostly well-formed sequences with random content
      full_runs = 0;
      while (pending_ops.size() < directed + RANDOM_OPS) begin
         pick  = $urandom_range(0, 9);
         drain = (pending_ops.size() == directed) || ($urandom_range(0, 11) == 0);
         if (full_runs < 2 && (pending_ops.size() == directed || pick == 0)) begin
            // Fill to the brim, overflow it, then pop between half and all of it
            full_runs++;
            queue_push(drain);
            while (gen_fill < lsmp_pkg::DEPTH) queue_push(1'b0);
            repeat ($urandom_range(1, 3)) queue_push(1'b0);
            queue_pop($urandom_range(0, 1) ? 64 : $urandom_range(lsmp_pkg::DEPTH / 2, 64),
                      1'b0);
         end else if (pick <= 2) begin
            queue_pop(0, drain);
         end else if (pick <= 5) begin
            queue_push(drain);
            repeat ($urandom_range(0, 5)) queue_push(1'b0);
         end else if (pick <= 8) begin
            queue_pop(($urandom_range(0, 3) == 0) ? $urandom_range(0, 64)
                                                  : $urandom_range(1, 8), drain);
         end else begin
            queue_pop((gen_fill < 64) ? gen_fill + $urandom_range(0, 1) : 64, drain);
         end
      end
      ops_total = pending_ops.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Wait for every request, then every response, then let the pipe settle
      while (ops_accepted < ops_total) @(negedge clock);
      while (awaited_results.size() > 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Ran %0d requests and %0d responses: %0d pushes (%0d dropped when full),",
               ops_accepted, results_seen, kind_tally[lsmp_pkg::KIND_PUSH], dropped_pushes);
      $display("  %0d words popped, %0d pops on empty, %0d pops of zero; %0d mismatches",
               kind_tally[lsmp_pkg::KIND_POPPED], kind_tally[lsmp_pkg::KIND_EMPTY],
               kind_tally[lsmp_pkg::KIND_ZERO], mismatches);
      if (mismatches == 0 && awaited_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Driver: present queued transactions, idling between them as drawn
   always @(posedge clock) begin
      if (reset) begin
         offering  = 1'b0;
         staged    = 1'b0;
         idle_left = 0;
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            apply_stack_op(next_op);
            ops_accepted++;
            offering = 1'b0;
            staged   = 1'b0;
         end
         if (!offering) begin
            if (!staged && pending_ops.size() > 0) begin
               next_op   = pending_ops.pop_front();
               staged    = 1'b1;
               idle_left = next_op.idle_cycles;
            end
            if (staged) begin
               if (idle_left > 0) begin
                  idle_left--;
               end else if (!next_op.drain_first || results_due == results_seen) begin
                  // Hold a drain-first transaction until all responses are in
                  req_cmd        <= next_op.cmd;
                  req_push_value <= next_op.value;
                  req_pop_count  <= next_op.count;
                  offering = 1'b1;
               end
            end
         end
         req_valid <= offering;
      end
   end

   // Monitor: check responses against the shadow stack and pace rsp_ready
   always @(posedge clock) begin
      lsmp_pkg::result_type want;
      logic                 ready_next;
      if (reset) begin
         stall_left = 0;
         rsp_ready <= 1'b0;
      end else begin
         ready_next = rsp_ready;
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected response %0d: kind %0d, fill %0d",
                           results_seen, rsp_kind, rsp_fill);
            end else begin
               want = awaited_results.pop_front();
               check_field("kind", 32'(want.kind), 32'(rsp_kind));
               check_field("popped_value", want.popped_value, rsp_popped_value);
               check_field("last", 32'(want.last), 32'(rsp_last));
               check_field("fill", 32'(want.fill), 32'(rsp_fill));
               check_field("is_empty", 32'(want.is_empty), 32'(rsp_is_empty));
               check_field("top_value", want.top_value, rsp_top_value);
               check_field("overflow", 32'(want.overflow), 32'(rsp_overflow));
            end
            kind_tally[rsp_kind]++;
            if (rsp_kind == lsmp_pkg::KIND_PUSH && rsp_overflow)
               dropped_pushes++;
            results_seen <= results_seen + 1;
            // Hold off once for a long stretch so the stack backs up
            if (!long_hold_done && results_seen + 1 == HOLD_AT_RSP) begin
               long_hold_done = 1'b1;
               stall_left = LONG_HOLD;
            end else begin
               stall_left = ((results_seen / 32) % 3 == 2) ? 0 : $urandom_range(0, 4);
            end
            ready_next = (stall_left == 0);
         end else if (!rsp_ready) begin
            if (stall_left > 0)
               stall_left--;
            if (stall_left == 0)
               ready_next = 1'b1;
         end
         rsp_ready <= ready_next;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lsmp_pkg.sv
rtl/lsmp_store.sv
rtl/lsmp_ctrl.sv
rtl/lsmp_out.sv
rtl/lifo_stack_multi_pop.sv
tb/lifo_stack_multi_pop_test.sv
